[rtl/bbc_pkg.sv]
// Shared types and constants of the block buffer cache.
package bbc_pkg;

    // Request opcodes
    localparam logic [1:0] OP_GET     = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_PIN     = 2'd2;
    localparam logic [1:0] OP_UNPIN   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_UNDER  = 2'd2;
    localparam logic [1:0] ST_OVER   = 2'd3;

    // Saturation value of the reference count
    localparam logic [7:0] COUNT_MAX = ~8'd0;

    // One buffer entry as stored in the entry memory
    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic        valid;
        logic [7:0]  count;
        logic [31:0] stamp;
    } t_entry;

    // One result beat
    typedef struct packed {
        logic [4:0] entry;
        logic       hit;
        logic       fill;
        logic [1:0] status;
    } t_result;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SCAN_TAIL,
        S_GET_WB,
        S_ACC_RD,
        S_ACC_WB,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic req_load;
        logic clr_wr;
        logic scan_issue;
        logic acc_issue;
        logic get_wb;
        logic acc_wb;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic addr_last;
        logic out_busy;
    } t_stat;

endpackage

[rtl/bbc_if.sv]
// Request and result channel interfaces of the block buffer cache.
interface bbc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  entry_index;
    logic [31:0] current_time;

    modport source (output valid, opcode, device, block_number, entry_index, current_time,
                    input ready);
    modport sink   (input valid, opcode, device, block_number, entry_index, current_time,
                    output ready);
endinterface

interface bbc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] entry_out;
    logic       hit;
    logic       needs_fill;
    logic [1:0] status;

    modport source (output valid, entry_out, hit, needs_fill, status, input ready);
    modport sink   (input valid, entry_out, hit, needs_fill, status, output ready);
endinterface

[rtl/bbc_ctrl.sv]
// Sequencing controller of the block buffer cache.
module bbc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_in_opcode,
    output logic           o_in_ready,
    input  bbc_pkg::t_stat i_stat,
    output bbc_pkg::t_cmd  o_cmd
);

    bbc_pkg::t_state r_state;
    bbc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbc_pkg::S_CLEAR: begin
                if (i_stat.addr_last) n_state = bbc_pkg::S_IDLE;
            end
            bbc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_opcode == bbc_pkg::OP_GET) ? bbc_pkg::S_SCAN
                                                               : bbc_pkg::S_ACC_RD;
                end
            end
            bbc_pkg::S_SCAN: begin
                if (i_stat.addr_last) n_state = bbc_pkg::S_SCAN_TAIL;
            end
            bbc_pkg::S_SCAN_TAIL: n_state = bbc_pkg::S_GET_WB;
            bbc_pkg::S_GET_WB:    n_state = bbc_pkg::S_DONE;
            bbc_pkg::S_ACC_RD:    n_state = bbc_pkg::S_ACC_WB;
            bbc_pkg::S_ACC_WB:    n_state = bbc_pkg::S_DONE;
            bbc_pkg::S_DONE: begin
                if (!i_stat.out_busy) n_state = bbc_pkg::S_IDLE;
            end
            default: n_state = bbc_pkg::S_CLEAR;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bbc_pkg::S_CLEAR: o_cmd.clr_wr = 1'b1;
            bbc_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.req_load = i_in_valid;
            end
            bbc_pkg::S_SCAN:      o_cmd.scan_issue = 1'b1;
            bbc_pkg::S_SCAN_TAIL: ;
            bbc_pkg::S_GET_WB:    o_cmd.get_wb = 1'b1;
            bbc_pkg::S_ACC_RD:    o_cmd.acc_issue = 1'b1;
            bbc_pkg::S_ACC_WB:    o_cmd.acc_wb = 1'b1;
            bbc_pkg::S_DONE:      o_cmd.out_load = !i_stat.out_busy;
            default: ;
        endcase
    end

endmodule

[rtl/bbc_dpath.sv]
// Entry memory, scan logic and result register of the block buffer cache.
module bbc_dpath #(
    parameter int NUM_ENTRIES = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bbc_pkg::t_cmd  i_cmd,
    output bbc_pkg::t_stat o_stat,
    input  logic [1:0]     i_opcode,
    input  logic [7:0]     i_device,
    input  logic [31:0]    i_block_number,
    input  logic [4:0]     i_entry_index,
    input  logic [31:0]    i_current_time,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [4:0]     o_entry_out,
    output logic           o_hit,
    output logic           o_needs_fill,
    output logic [1:0]     o_status
);

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    bbc_pkg::t_entry r_mem [NUM_ENTRIES];
    bbc_pkg::t_entry r_rd_data;

    logic [IDX_W-1:0] r_addr;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    logic [1:0]  r_op;
    logic [7:0]  r_dev;
    logic [31:0] r_blk;
    logic [4:0]  r_idx;
    logic [31:0] r_time;

    logic             r_hit_found;
    logic [IDX_W-1:0] r_hit_idx;
    bbc_pkg::t_entry  r_hit_ent;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    logic [31:0]      r_free_stamp;

    bbc_pkg::t_result r_res;
    bbc_pkg::t_result r_out;
    logic             r_out_valid;

    bbc_pkg::t_result n_res;
    logic             n_wr_en;
    logic [IDX_W-1:0] n_wr_addr;
    bbc_pkg::t_entry  n_wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] idx_addr;
    logic             idx_in_range;
    logic             scan_match;
    logic             scan_free;

    assign idx_addr     = IDX_W'(r_idx);
    assign idx_in_range = (32'(r_idx) < 32'(NUM_ENTRIES));
    assign rd_addr      = i_cmd.acc_issue ? idx_addr : r_addr;

    assign o_stat.addr_last = (r_addr == LAST_IDX);
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (n_wr_en) r_mem[n_wr_addr] <= n_wr_data;
        r_rd_data <= r_mem[rd_addr];
    end

    // Advance the sweep address for the clearing pass and the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.req_load) begin
                r_addr <= '0;
            end else if (i_cmd.clr_wr || i_cmd.scan_issue) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            r_rd_vld <= i_cmd.scan_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_issue) r_rd_idx <= r_addr;
    end

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_op   <= i_opcode;
            r_dev  <= i_device;
            r_blk  <= i_block_number;
            r_idx  <= i_entry_index;
            r_time <= i_current_time;
        end
    end

    // Compare each scanned entry against the tag and the oldest free entry so far
    assign scan_match = (r_rd_data.dev == r_dev) && (r_rd_data.blk == r_blk);
    assign scan_free  = (r_rd_data.count == 8'd0)
                        && (!r_free_found || (r_rd_data.stamp < r_free_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.req_load) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_rd_vld) begin
            if (scan_match && !r_hit_found) r_hit_found <= 1'b1;
            if (scan_free) r_free_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && scan_match && !r_hit_found) begin
            r_hit_idx <= r_rd_idx;
            r_hit_ent <= r_rd_data;
        end
        if (r_rd_vld && scan_free) begin
            r_free_idx   <= r_rd_idx;
            r_free_stamp <= r_rd_data.stamp;
        end
    end

    // Write-back and result of the finished request
    always_comb begin
        n_wr_en   = 1'b0;
        n_wr_addr = r_addr;
        n_wr_data = '0;
        n_res     = r_res;
        if (i_cmd.clr_wr) begin
            n_wr_en = 1'b1;
        end else if (i_cmd.get_wb) begin
            if (r_hit_found) begin
                n_res.entry = 5'(r_hit_idx);
                n_res.hit   = 1'b1;
                if (r_hit_ent.count == bbc_pkg::COUNT_MAX) begin
                    n_res.fill   = 1'b0;
                    n_res.status = bbc_pkg::ST_OVER;
                end else begin
                    n_res.fill            = !r_hit_ent.valid;
                    n_res.status          = bbc_pkg::ST_OK;
                    n_wr_en               = 1'b1;
                    n_wr_addr             = r_hit_idx;
                    n_wr_data             = r_hit_ent;
                    n_wr_data.valid       = 1'b1;
                    n_wr_data.count       = r_hit_ent.count + 8'd1;
                end
            end else if (r_free_found) begin
                n_res.entry     = 5'(r_free_idx);
                n_res.hit       = 1'b0;
                n_res.fill      = 1'b1;
                n_res.status    = bbc_pkg::ST_OK;
                n_wr_en         = 1'b1;
                n_wr_addr       = r_free_idx;
                n_wr_data.dev   = r_dev;
                n_wr_data.blk   = r_blk;
                n_wr_data.valid = 1'b1;
                n_wr_data.count = 8'd1;
                n_wr_data.stamp = r_free_stamp;
            end else begin
                n_res.entry  = 5'd0;
                n_res.hit    = 1'b0;
                n_res.fill   = 1'b0;
                n_res.status = bbc_pkg::ST_NOFREE;
            end
        end else if (i_cmd.acc_wb) begin
            n_res.entry  = r_idx;
            n_res.hit    = 1'b0;
            n_res.fill   = 1'b0;
            n_res.status = bbc_pkg::ST_OK;
            n_wr_addr    = idx_addr;
            n_wr_data    = r_rd_data;
            if (idx_in_range) begin
                if (r_op == bbc_pkg::OP_PIN) begin
                    if (r_rd_data.count == bbc_pkg::COUNT_MAX) begin
                        n_res.status = bbc_pkg::ST_OVER;
                    end else begin
                        n_wr_en         = 1'b1;
                        n_wr_data.count = r_rd_data.count + 8'd1;
                    end
                end else if (r_rd_data.count == 8'd0) begin
                    n_res.status = bbc_pkg::ST_UNDER;
                end else begin
                    n_wr_en         = 1'b1;
                    n_wr_data.count = r_rd_data.count - 8'd1;
                    // Stamp the time on the final release
                    if (r_op == bbc_pkg::OP_RELEASE && r_rd_data.count == 8'd1) begin
                        n_wr_data.stamp = r_time;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.get_wb || i_cmd.acc_wb) r_res <= n_res;
        if (i_cmd.out_load) r_out <= r_res;
    end

    // Hold the result beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_entry_out  = r_out.entry;
    assign o_hit        = r_out.hit;
    assign o_needs_fill = r_out.fill;
    assign o_status     = r_out.status;

endmodule

[rtl/block_buffer_cache_lru.sv]
// Top level of the block buffer cache with LRU replacement and reference counts.
// A table of NUM_ENTRIES buffer entries, each with a device/block tag, a valid flag,
// an 8-bit reference count and a release stamp, held in one single-port-read entry
// memory. A get reads every entry once, one per cycle, to find the lowest matching
// tag and the oldest unreferenced entry; release, pin and unpin read and rewrite
// one entry. One request is worked on at a time; a finished result waits in the
// output register while the next request is accepted. After reset the block runs a
// clearing pass over every entry with the request channel not ready.
module block_buffer_cache_lru #(
    parameter int NUM_ENTRIES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bbc_in_if.sink     i_in,
    bbc_out_if.source  o_out
);

    bbc_pkg::t_cmd  cmd;
    bbc_pkg::t_stat stat;

    bbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .o_in_ready  (i_in.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bbc_dpath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (i_in.opcode),
        .i_device       (i_in.device),
        .i_block_number (i_in.block_number),
        .i_entry_index  (i_in.entry_index),
        .i_current_time (i_in.current_time),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_entry_out    (o_out.entry_out),
        .o_hit          (o_out.hit),
        .o_needs_fill   (o_out.needs_fill),
        .o_status       (o_out.status)
    );

endmodule

[rtl/bbc_checker.sv]
// Port-level assertions of the block buffer cache and their bind.
module bbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [4:0] i_entry_out,
    input logic       i_hit,
    input logic       i_needs_fill,
    input logic [1:0] i_status
);

    logic [1:0] r_pend;

    // Track requests accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + 2'((i_in_valid && i_in_ready) ? 1 : 0)
                             - 2'((i_out_valid && i_out_ready) ? 1 : 0);
        end
    end

    // A result beat always answers an accepted request, and at most two are in flight
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || r_pend != 2'd0) && (r_pend != 2'd3))
        else $error("result beat without a pending request");

    // A stalled result beat holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_entry_out) && $stable(i_hit)
         && $stable(i_needs_fill) && $stable(i_status)))
        else $error("stalled result beat changed");

    // A disk fill is requested only on a successful get
    a_fill_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_needs_fill) |-> (i_status == bbc_pkg::ST_OK))
        else $error("fill flagged on a failed request");

    // No free buffer reports entry zero, no hit and no fill
    a_nofree_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == bbc_pkg::ST_NOFREE)
        |-> (!i_hit && !i_needs_fill && i_entry_out == 5'd0))
        else $error("no-free result carries entry data");

endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_entry_out  (o_out.entry_out),
    .i_hit        (o_out.hit),
    .i_needs_fill (o_out.needs_fill),
    .i_status     (o_out.status)
);
